// ===== rtl/core/cqp_pkg.sv =====
// ============================================================================
// cqp_pkg: shared types and codes of the command queue
// Request and response item layouts, the entry held by each queue cell, the
// per-cell control bundle and the request, status and purge codes.
// ============================================================================
package cqp_pkg;

    // Request types
    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;
    localparam logic [1:0] REQ_CLR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Command codes that can trigger a purge before they are appended
    localparam logic [2:0] CODE_SEEK = 3'd2;
    localparam logic [2:0] CODE_ANY  = 3'd7;

    localparam int FILL_OUT_W = 5;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         cmd_code;
        logic signed [31:0] arg_a;
        logic signed [31:0] arg_b;
        logic signed [31:0] arg_c;
    } t_req;

    typedef struct packed {
        logic [2:0]            head_code;
        logic signed [31:0]    head_a;
        logic signed [31:0]    head_b;
        logic signed [31:0]    head_c;
        logic [FILL_OUT_W-1:0] fill_count;
        logic [1:0]            status;
    } t_rsp;

    typedef struct packed {
        logic [2:0]         code;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } t_entry;

    typedef struct packed {
        logic       clear;      // drop the entry
        logic       load;       // first free cell takes the new entry
        logic       purge_en;   // this cell may match and be removed
        logic       need_b;     // match also requires b == 1
        logic [2:0] match_code;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/cqp_cell.sv =====
// ============================================================================
// cqp_cell: one slot of the command queue
// Holds one entry and its valid bit. A remove signal ripples upward through
// the row: once it is set at a cell, that cell takes its upper neighbour's
// entry, which closes the gap left by the removed entry.
// ============================================================================
module cqp_cell
    import cqp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_remove,       // an entry below this slot goes
    input  logic       i_lower_valid,
    input  t_entry     i_upper,
    input  logic       i_upper_valid,
    input  t_entry     i_new,
    output logic       o_remove,
    output t_entry     o_entry,
    output logic       o_valid
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   w_hit;

    assign w_hit = i_ctrl.purge_en && r_valid && (r_entry.code == i_ctrl.match_code)
                   && (!i_ctrl.need_b || (r_entry.b == 32'sd1));
    assign o_remove = i_remove || w_hit;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (o_remove) begin
            n_valid = i_upper_valid;
            n_entry = i_upper;
        end else if (i_ctrl.load && !r_valid && i_lower_valid) begin
            n_valid = 1'b1;
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/command_queue_with_purge.sv =====
// ============================================================================
// command_queue_with_purge: command FIFO with duplicate purge
// A row of queue cells driven by a small request sequencer.
// ============================================================================
// Each request item returns one response item carrying the head entry, the
// fill level and a status. Enqueue, dequeue and clear change the cells in
// the apply state and then load the response register in the done state. An
// enqueue on a full queue, a dequeue on an empty queue and the unused request
// type do not touch the cells, so they go straight to the done state. An
// enqueue of code 2 with arg_b equal to 1, or of code 7, first runs a purge
// that removes one matching entry per cycle from slot 1 upward and ends once
// none is left, before it is applied. The input is stalled from acceptance
// until the response register is loaded. The next request is accepted while
// the previous response still waits to be taken, but it cannot finish until
// that response has gone.
module command_queue_with_purge
    import cqp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PURGE = 4'b0010,
        S_APPLY = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    t_req                r_req;
    t_rsp                r_out;
    logic                r_out_valid;

    logic                w_accept;
    logic                w_full;
    logic                w_purge_req;
    logic                w_out_load;
    logic [QUEUE_DEPTH:0]   w_rm;
    logic [QUEUE_DEPTH-1:0] w_valid;
    t_entry              w_entry [QUEUE_DEPTH];
    t_cell_ctrl          w_ctrl [QUEUE_DEPTH];
    t_entry              w_new;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_purge_req = ((i_req.cmd_code == CODE_SEEK) && (i_req.arg_b == 32'sd1))
                         || (i_req.cmd_code == CODE_ANY);
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    assign w_new.code = r_req.cmd_code;
    assign w_new.a    = r_req.arg_a;
    assign w_new.b    = r_req.arg_b;
    assign w_new.c    = r_req.arg_c;

    // A dequeue enters the remove chain at the head; a purge enters it at
    // the first matching cell above the head.
    assign w_rm[0] = (r_state == S_APPLY) && (r_req.req_type == REQ_DEQ);

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cells
        assign w_ctrl[g].clear      = (r_state == S_APPLY) && (r_req.req_type == REQ_CLR);
        assign w_ctrl[g].load       = (r_state == S_APPLY) && (r_req.req_type == REQ_ENQ);
        assign w_ctrl[g].purge_en   = (r_state == S_PURGE) && (g != 0);
        assign w_ctrl[g].need_b     = (r_req.cmd_code == CODE_SEEK);
        assign w_ctrl[g].match_code = r_req.cmd_code;

        if (g == QUEUE_DEPTH - 1) begin : g_top
            cqp_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl[g]),
                .i_remove      (w_rm[g]),
                .i_lower_valid (w_valid[g-1]),
                .i_upper       ('0),
                .i_upper_valid (1'b0),
                .i_new         (w_new),
                .o_remove      (w_rm[g+1]),
                .o_entry       (w_entry[g]),
                .o_valid       (w_valid[g])
            );
        end else if (g == 0) begin : g_head
            cqp_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl[g]),
                .i_remove      (w_rm[g]),
                .i_lower_valid (1'b1),
                .i_upper       (w_entry[g+1]),
                .i_upper_valid (w_valid[g+1]),
                .i_new         (w_new),
                .o_remove      (w_rm[g+1]),
                .o_entry       (w_entry[g]),
                .o_valid       (w_valid[g])
            );
        end else begin : g_mid
            cqp_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl[g]),
                .i_remove      (w_rm[g]),
                .i_lower_valid (w_valid[g-1]),
                .i_upper       (w_entry[g+1]),
                .i_upper_valid (w_valid[g+1]),
                .i_new         (w_new),
                .o_remove      (w_rm[g+1]),
                .o_entry       (w_entry[g]),
                .o_valid       (w_valid[g])
            );
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    unique case (i_req.req_type)
                        REQ_ENQ: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (w_purge_req) begin
                                n_state = S_PURGE;
                            end else begin
                                n_state = S_APPLY;
                            end
                        end
                        REQ_DEQ: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_APPLY;
                            end
                        end
                        REQ_CLR: n_state = S_APPLY;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PURGE: begin
                // One matching entry leaves per cycle until none is left.
                if (w_rm[QUEUE_DEPTH]) begin
                    n_fill = r_fill - 1'b1;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_DONE;
                unique case (r_req.req_type)
                    REQ_ENQ: n_fill = r_fill + 1'b1;
                    REQ_DEQ: n_fill = r_fill - 1'b1;
                    default: n_fill = '0;
                endcase
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_out_load) begin
            r_out.head_code  <= w_valid[0] ? w_entry[0].code : 3'd0;
            r_out.head_a     <= w_valid[0] ? w_entry[0].a : 32'sd0;
            r_out.head_b     <= w_valid[0] ? w_entry[0].b : 32'sd0;
            r_out.head_c     <= w_valid[0] ? w_entry[0].c : 32'sd0;
            r_out.fill_count <= FILL_OUT_W'(r_fill);
            r_out.status     <= r_status;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // The fill level always equals the number of occupied cells.
    a_fill_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_fill))
        else $error("fill level differs from occupied cells");

    // Occupied cells form an unbroken run from the head.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("gap in the occupied cells");

    // A purge only ends once no matching entry is left.
    a_purge_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PURGE) && (n_state == S_APPLY) |-> !w_rm[QUEUE_DEPTH])
        else $error("purge ended with a match left");

    // An entry is never appended to a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) && (r_req.req_type == REQ_ENQ) |-> !w_full)
        else $error("enqueue applied to a full queue");

    // A response is only loaded once the previous one has been taken.
    a_out_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || !i_stall))
        else $error("response overwritten while stalled");

endmodule
